/* design/xbs_pkg.sv */
package xbs_pkg;

    // Default data bytes per block
    localparam int XBS_BLOCK_BYTES = 128;

    // Line control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_C   = 8'h43;

    // Input transaction kinds
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_REPLY = 2'd2;
    localparam logic [1:0] MODE_TICK  = 2'd3;

    // Config register indexes and reset values
    localparam logic       CFG_START_NUMBER = 1'b0;
    localparam logic       CFG_PAD_BYTE     = 1'b1;
    localparam logic [7:0] START_NUMBER_RST = 8'd1;
    localparam logic [7:0] PAD_BYTE_RST     = 8'd26;

    // CRC-16/X.25, reflected polynomial
    localparam logic [15:0] CRC_POLY = 16'h8408;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_COLLECT,
        PH_SENDING,
        PH_AWAIT,
        PH_DONE,
        PH_CANCEL
    } t_phase;

    // What the second stage puts on the line
    typedef enum logic [3:0] {
        EM_NONE,
        EM_EOT,
        EM_SOH,
        EM_NUM,
        EM_INV,
        EM_DATA,
        EM_PAD,
        EM_CRC_LO,
        EM_CRC_HI
    } t_emit;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* design/xmodem_block_sender.sv */
// XModem block sender, CRC-16/X.25 check bytes.
// Each input transaction passes the stage 1 register (block buffer read is registered), then the output register.
// Throughput: one input transaction per cycle while the result stream is not stalled, one result per input transaction.
// Reset: synchronous, active low (i_rst_n); clears session state, crc to all ones,
// start_number to 1 and pad_byte to 26. The block buffer is not cleared.
module xmodem_block_sender
    import xbs_pkg::*;
#(
    parameter int BLOCK_BYTES = XBS_BLOCK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] reply_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] line_byte
    output logic        m_axis_tlast,   // block_end
    output logic [2:0]  m_axis_tuser    // [0] line_valid, [1] finished, [2] cancelled
);

    localparam int AW = $clog2(BLOCK_BYTES);
    localparam int FW = $clog2(BLOCK_BYTES + 1);
    localparam int IW = $clog2(BLOCK_BYTES + 5);

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [7:0] r_start_number;
    logic [7:0] r_pad_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_number <= START_NUMBER_RST;
            r_pad_byte     <= PAD_BYTE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_START_NUMBER: r_start_number <= i_cfg_wdata;
                CFG_PAD_BYTE:     r_pad_byte     <= i_cfg_wdata;
                default:          r_pad_byte     <= r_pad_byte;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: two-stage pipe, stage 1 holds emit decision plus the
    // buffer read, stage 2 is the output register (and owns the CRC).
    // ---------------------------------------------------------------
    logic r_p_valid;
    logic r_o_valid;
    logic w_adv;
    logic w_acc;

    assign w_adv         = !r_o_valid || m_axis_tready;
    assign s_axis_tready = !r_p_valid || w_adv;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // Session control state
    // ---------------------------------------------------------------
    t_phase         r_phase,  n_phase;
    logic [FW-1:0]  r_fill,   n_fill;
    logic           r_src_done, n_src_done;
    logic [7:0]     r_bn,     n_bn;
    logic [IW-1:0]  r_idx,    n_idx;
    logic           r_go,     n_go;

    // stage 1 next values
    t_emit          n_kind;
    logic [7:0]     n_byte;

    // buffer access
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [AW-1:0]  w_raddr;
    logic           w_re;
    logic [IW-1:0]  w_pos;

    logic [1:0]     w_mode;
    logic [7:0]     w_dbyte;
    logic [7:0]     w_rbyte;
    logic           w_ended;

    assign w_mode  = s_axis_tuser;
    assign w_dbyte = s_axis_tdata[7:0];
    assign w_rbyte = s_axis_tdata[15:8];
    assign w_ended = (r_phase == PH_DONE) || (r_phase == PH_CANCEL);
    assign w_pos   = r_idx - IW'(3);       // data position while sending
    assign w_waddr = r_fill[AW-1:0];
    assign w_raddr = w_pos[AW-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_fill     = r_fill;
        n_src_done = r_src_done;
        n_bn       = r_bn;
        n_idx      = r_idx;
        n_go       = r_go;
        n_kind     = EM_NONE;
        n_byte     = 8'h00;
        w_we       = 1'b0;
        w_re       = 1'b0;

        if (w_acc && !w_ended) begin
            unique case (w_mode)
                MODE_DATA: begin
                    // bytes past the end of source or into a full block are dropped
                    if (!r_src_done && (r_fill < FW'(BLOCK_BYTES))) begin
                        w_we   = 1'b1;
                        n_fill = r_fill + FW'(1);
                    end
                end
                MODE_END: begin
                    n_src_done = 1'b1;
                end
                MODE_REPLY: begin
                    case (w_rbyte) inside
                        CH_CAN: begin
                            n_phase = PH_CANCEL;
                        end
                        CH_NAK, CH_C: begin
                            if (r_phase == PH_COLLECT && !r_go) begin
                                // session start (or re-grant before any block)
                                n_go = 1'b1;
                                n_bn = r_start_number;
                            end else if (r_phase == PH_AWAIT) begin
                                // resend current block
                                n_phase = PH_COLLECT;
                                n_go    = 1'b1;
                            end
                        end
                        CH_ACK: begin
                            if (r_phase == PH_AWAIT) begin
                                n_bn    = r_bn + 8'd1;
                                n_fill  = '0;
                                n_phase = PH_COLLECT;
                                n_go    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                MODE_TICK: begin
                    if (r_phase == PH_COLLECT && r_go &&
                        ((r_fill == FW'(BLOCK_BYTES)) || r_src_done)) begin
                        n_go = 1'b0;
                        if (r_fill == '0) begin
                            n_kind  = EM_EOT;
                            n_byte  = CH_EOT;
                            n_phase = PH_DONE;
                        end else begin
                            n_kind  = EM_SOH;
                            n_byte  = CH_SOH;
                            n_phase = PH_SENDING;
                            n_idx   = IW'(1);
                        end
                    end else if (r_phase == PH_SENDING) begin
                        n_idx = r_idx + IW'(1);
                        if (r_idx == IW'(1)) begin
                            n_kind = EM_NUM;
                            n_byte = r_bn;
                        end else if (r_idx == IW'(2)) begin
                            n_kind = EM_INV;
                            n_byte = ~r_bn;
                        end else if (r_idx < IW'(BLOCK_BYTES + 3)) begin
                            if (w_pos < IW'(r_fill)) begin
                                n_kind = EM_DATA;
                                w_re   = 1'b1;
                            end else begin
                                n_kind = EM_PAD;
                                n_byte = r_pad_byte;
                            end
                        end else if (r_idx == IW'(BLOCK_BYTES + 3)) begin
                            n_kind = EM_CRC_LO;
                        end else begin
                            n_kind  = EM_CRC_HI;
                            n_phase = PH_AWAIT;
                            n_idx   = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_COLLECT;
            r_fill     <= '0;
            r_src_done <= 1'b0;
            r_bn       <= START_NUMBER_RST;
            r_idx      <= '0;
            r_go       <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_fill     <= n_fill;
            r_src_done <= n_src_done;
            r_bn       <= n_bn;
            r_idx      <= n_idx;
            r_go       <= n_go;
        end
    end

    // ---------------------------------------------------------------
    // Block buffer: one write port (source fill), one registered read
    // port (send). Writes and data reads never share a cycle.
    // ---------------------------------------------------------------
    logic [7:0] r_mem [BLOCK_BYTES];
    logic [7:0] r_mem_q;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_dbyte;
        end
        if (w_re) begin
            r_mem_q <= r_mem[w_raddr];
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 register
    // ---------------------------------------------------------------
    t_emit      r_p_kind;
    logic [7:0] r_p_byte;
    logic       r_p_fin;
    logic       r_p_can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_acc) begin
            r_p_valid <= 1'b1;
        end else if (w_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_kind <= n_kind;
            r_p_byte <= n_byte;
            r_p_fin  <= (n_phase == PH_DONE) || (n_phase == PH_CANCEL);
            r_p_can  <= (n_phase == PH_CANCEL);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: byte select, CRC accumulate, output register
    // ---------------------------------------------------------------
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  w_sel;
    logic [7:0]  n_line;
    logic        w_p_move;

    assign w_p_move = r_p_valid && w_adv;
    assign w_sel    = (r_p_kind == EM_DATA) ? r_mem_q : r_p_byte;

    always_comb begin
        n_crc  = r_crc;
        n_line = w_sel;
        case (r_p_kind) inside
            EM_SOH:          n_crc  = CRC_INIT;
            EM_DATA, EM_PAD: n_crc  = crc_step(r_crc, w_sel);
            EM_CRC_LO:       n_line = ~r_crc[7:0];
            EM_CRC_HI:       n_line = ~r_crc[15:8];
            default: ;
        endcase
    end

    logic [7:0] r_o_byte;
    logic       r_o_lv;
    logic       r_o_last;
    logic       r_o_fin;
    logic       r_o_can;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_crc     <= CRC_INIT;
        end else if (w_adv) begin
            r_o_valid <= r_p_valid;
            if (r_p_valid) begin
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_p_move) begin
            r_o_byte <= n_line;
            r_o_lv   <= (r_p_kind != EM_NONE);
            r_o_last <= (r_p_kind == EM_CRC_HI) || (r_p_kind == EM_EOT);
            r_o_fin  <= r_p_fin;
            r_o_can  <= r_p_can;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_byte;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = {r_o_can, r_o_fin, r_o_lv};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_end_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE || r_phase == PH_CANCEL) |=> (r_phase == $past(r_phase)))
        else $error("ended session left its final phase");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(BLOCK_BYTES))
        else $error("fill count beyond block size");

    a_no_fill_while_sending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SENDING) |-> !w_we)
        else $error("buffer written during block transmission");

    a_last_is_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
        else $error("block end without a line byte");

    a_cancel_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> m_axis_tuser[1])
        else $error("cancelled without finished");

endmodule

/* sim/xbs_tb_pkg.sv */
package xbs_tb_pkg;

    import xbs_pkg::*;

    localparam int BLK = XBS_BLOCK_BYTES;

    // One line result as the block reports it
    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_valid;
        logic       block_end;
        logic       finished;
        logic       cancelled;
    } t_line_out;

    class xmodem_line_scoreboard;

        // register copies
        logic [7:0] start_num;
        logic [7:0] pad;

        // session state
        logic [7:0] blk_buf [BLK];
        int         fill;
        bit         src_done;
        logic [7:0] blk_num;
        t_phase     ph;
        int         tx_idx;
        logic [15:0] crc;
        bit         granted;

        t_line_out  line_outputs [$];
        int         errors;
        int         checked;
        int         blocks_sent;

        function new();
            start_num   = START_NUMBER_RST;
            pad         = PAD_BYTE_RST;
            fill        = 0;
            src_done    = 1'b0;
            blk_num     = START_NUMBER_RST;
            ph          = PH_COLLECT;
            tx_idx      = 0;
            crc         = CRC_INIT;
            granted     = 1'b0;
            errors      = 0;
            checked     = 0;
            blocks_sent = 0;
        endfunction

        function void set_reg(input logic idx, input logic [7:0] val);
            if (idx == CFG_START_NUMBER)
                start_num = val;
            else
                pad = val;
        endfunction

        function int pending();
            return line_outputs.size();
        endfunction

        // reflected CRC-16 (X.25), one byte
        function logic [15:0] crc_x25_byte(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] v;
            v = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            return v;
        endfunction

        // Accepted input transaction: advance the session, queue the line result
        function void note_input(input logic [1:0] md, input logic [7:0] db,
                                 input logic [7:0] rb);
            t_line_out   r;
            bit          ended;
            logic [15:0] fin;
            int          p;
            r     = '0;
            ended = (ph == PH_DONE || ph == PH_CANCEL);
            if (!ended) begin
                case (md)
                    MODE_DATA: begin
                        if (!src_done && fill < BLK) begin
                            blk_buf[fill] = db;
                            fill++;
                        end
                    end
                    MODE_END: src_done = 1'b1;
                    MODE_REPLY: begin
                        if (rb == CH_CAN) begin
                            ph = PH_CANCEL;
                        end else if (rb == CH_NAK || rb == CH_C) begin
                            if (ph == PH_COLLECT && !granted) begin
                                granted = 1'b1;
                                blk_num = start_num;
                            end else if (ph == PH_AWAIT) begin
                                ph      = PH_COLLECT;
                                granted = 1'b1;
                            end
                        end else if (rb == CH_ACK && ph == PH_AWAIT) begin
                            blk_num = blk_num + 8'd1;
                            fill    = 0;
                            ph      = PH_COLLECT;
                            granted = 1'b1;
                        end
                    end
                    default: begin
                        if (ph == PH_COLLECT && granted && (fill >= BLK || src_done)) begin
                            granted      = 1'b0;
                            r.line_valid = 1'b1;
                            if (fill == 0) begin
                                r.line_byte = CH_EOT;
                                r.block_end = 1'b1;
                                ph          = PH_DONE;
                            end else begin
                                r.line_byte = CH_SOH;
                                ph          = PH_SENDING;
                                tx_idx      = 1;
                                crc         = CRC_INIT;
                            end
                        end else if (ph == PH_SENDING) begin
                            fin          = ~crc;
                            r.line_valid = 1'b1;
                            if (tx_idx == 1) begin
                                r.line_byte = blk_num;
                            end else if (tx_idx == 2) begin
                                r.line_byte = 8'd255 - blk_num;
                            end else if (tx_idx < 3 + BLK) begin
                                p           = tx_idx - 3;
                                r.line_byte = (p < fill) ? blk_buf[p] : pad;
                                crc         = crc_x25_byte(crc, r.line_byte);
                            end else if (tx_idx == 3 + BLK) begin
                                r.line_byte = fin[7:0];
                            end else begin
                                r.line_byte = fin[15:8];
                                r.block_end = 1'b1;
                                ph          = PH_AWAIT;
                                blocks_sent++;
                            end
                            tx_idx = r.block_end ? 0 : tx_idx + 1;
                        end
                    end
                endcase
            end
            r.finished  = (ph == PH_DONE || ph == PH_CANCEL);
            r.cancelled = (ph == PH_CANCEL);
            line_outputs.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [7:0] e,
                                    input logic [7:0] a);
            if (a !== e) begin
                $error("%s mismatch: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_line(input logic [7:0] line, input logic last,
                                 input logic [2:0] user);
            t_line_out e;
            if (line_outputs.size() == 0) begin
                $error("line result %0h arrived with nothing predicted", line);
                errors++;
                return;
            end
            e = line_outputs.pop_front();
            checked++;
            compare_field("line_byte", e.line_byte, line);
            compare_field("line_valid", {7'd0, e.line_valid}, {7'd0, user[0]});
            compare_field("block_end", {7'd0, e.block_end}, {7'd0, last});
            compare_field("finished", {7'd0, e.finished}, {7'd0, user[1]});
            compare_field("cancelled", {7'd0, e.cancelled}, {7'd0, user[2]});
        endfunction

    endclass

endpackage

/* sim/tb_top.sv */
module tb_top;

    import xbs_pkg::*;
    import xbs_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int BLOCK_TICKS = 3 + BLK + 2;    // SOH, number, inverse, data, two CRC

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [7:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;     // [7:0] data_byte, [15:8] reply_byte
    logic [1:0]  s_axis_tuser;     // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [7:0] line_byte
    logic        m_axis_tlast;     // block_end
    logic [2:0]  m_axis_tuser;     // [0] line_valid, [1] finished, [2] cancelled

    xmodem_line_scoreboard sb = new();

    int  cycle_count    = 0;
    int  items_sent     = 0;
    int  burst_left     = 0;
    bit  drv_valid      = 1'b0;
    bit  want_long_hold = 1'b0;
    bit  long_hold_done = 1'b0;
    bit  end_by_cancel;

    always #5 i_clk = ~i_clk;

    xmodem_block_sender dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // reply byte that the block must ignore in every phase
    function automatic logic [7:0] quiet_reply();
        logic [7:0] b;
        b = rnd8();
        while (b == CH_ACK || b == CH_NAK || b == CH_CAN || b == CH_C)
            b = rnd8();
        return b;
    endfunction

    // One input transaction. Sender runs in bursts; a gap separates bursts
    // so tvalid never drops and rises in one step.
    task automatic send_item(input logic [1:0] md, input logic [7:0] db,
                             input logic [7:0] rb);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rb, db};
        s_axis_tuser  <= md;
        drv_valid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(md, db, rb);
        items_sent++;
        burst_left--;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            drv_valid = 1'b0;
        end
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        if (drv_valid) begin
            s_axis_tvalid <= 1'b0;
            drv_valid = 1'b0;
        end
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // One register write; the enable is dropped again before the task returns
    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Occasional transaction that leaves the session where it is.
    // Which kinds are harmless depends on the phase the caller is in.
    task automatic maybe_noise(input bit tick_ok, input bit ctl_ok, input bit data_ok);
        int         pick;
        logic [7:0] rb;
        if ($urandom_range(0, 11) != 0)
            return;
        pick = $urandom_range(0, 3);
        rb   = ($urandom_range(0, 2) == 0) ? CH_ACK :
               (($urandom_range(0, 1) == 0) ? CH_NAK : CH_C);
        if (pick == 0 && tick_ok)
            send_item(MODE_TICK, rnd8(), rnd8());
        else if (pick == 1 && ctl_ok)
            send_item(MODE_REPLY, rnd8(), rb);
        else if (pick == 2 && data_ok)
            send_item(MODE_DATA, rnd8(), rnd8());
        else
            send_item(MODE_REPLY, rnd8(), quiet_reply());
    endtask

    // Source bytes into a granted, still incomplete block
    task automatic fill_bytes(input int n, input bit trigger_hold);
        for (int i = 0; i < n; i++) begin
            if (trigger_hold && i == n / 3)
                want_long_hold = 1'b1;
            maybe_noise(1'b1, 1'b1, 1'b0);
            send_item(MODE_DATA, rnd8(), rnd8());
        end
    endtask

    // Ticks for one whole block; cancel_at >= 0 sends CAN at that tick instead
    task automatic send_block(input int cancel_at);
        for (int i = 0; i < BLOCK_TICKS; i++) begin
            if (i == cancel_at) begin
                send_item(MODE_REPLY, rnd8(), CH_CAN);
                return;
            end
            send_item(MODE_TICK, rnd8(), rnd8());
            if (i < BLOCK_TICKS - 1)
                maybe_noise(1'b0, 1'b1, 1'b1);
        end
    endtask

    // Receiver: checks each result transaction and stalls on its own pattern,
    // plus one long hold-off requested by the sender.
    initial begin
        int pat_left;
        int pat_kind;
        int hold_left;
        pat_left  = 0;
        pat_kind  = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_line(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (want_long_hold && !long_hold_done) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (pat_left == 0) begin
                pat_kind = $urandom_range(0, 2);
                pat_left = $urandom_range(10, 60);
            end
            pat_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (pat_kind)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int n_short;
        int cancel_at;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= CFG_START_NUMBER;
        i_cfg_wdata   <= 8'd0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'd0;
        s_axis_tuser  <= MODE_DATA;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Last write before the first grant wins; 255 makes the count wrap
        write_reg(CFG_START_NUMBER, 8'd0);
        write_reg(CFG_START_NUMBER, 8'd255);

        // --- directed opening ---
        send_item(MODE_TICK, rnd8(), rnd8());          // no grant yet: idle
        send_item(MODE_REPLY, rnd8(), CH_ACK);         // ACK before any block
        send_item(MODE_REPLY, 8'h00, 8'h00);           // unknown replies
        send_item(MODE_REPLY, 8'hFF, 8'hFF);
        send_item(MODE_DATA, 8'h00, rnd8());           // buffered before grant
        send_item(MODE_DATA, 8'hFF, rnd8());
        send_item(MODE_REPLY, rnd8(), CH_C);           // grant, number loaded
        send_item(MODE_REPLY, rnd8(), CH_NAK);         // grant already pending
        send_item(MODE_TICK, rnd8(), rnd8());          // block incomplete: idle

        // --- first block: full, with the long receiver hold-off inside ---
        fill_bytes(BLK - 2, 1'b1);
        repeat (3) send_item(MODE_DATA, rnd8(), rnd8());  // buffer full: dropped
        send_block(-1);
        send_item(MODE_TICK, rnd8(), rnd8());          // awaiting reply: idle
        send_item(MODE_DATA, rnd8(), rnd8());
        send_item(MODE_REPLY, rnd8(), CH_ACK);         // number wraps to 0
        drain();

        // start number no longer matters mid-session
        write_reg(CFG_PAD_BYTE, 8'd0);
        write_reg(CFG_START_NUMBER, rnd8());

        // --- short last block ---
        n_short = $urandom_range(1, 16);
        fill_bytes(n_short, 1'b0);
        send_item(MODE_END, rnd8(), rnd8());
        repeat (2) send_item(MODE_DATA, rnd8(), rnd8());  // after end: dropped
        send_item(MODE_END, rnd8(), rnd8());
        send_block(-1);
        drain();

        // --- session end: resend with the other pad extreme and cancel
        // inside the padding, or acknowledge and close with EOT ---
        end_by_cancel = 1'($urandom_range(0, 1));
        if (end_by_cancel) begin
            write_reg(CFG_PAD_BYTE, 8'd255);
            send_item(MODE_REPLY, rnd8(), ($urandom_range(0, 1) == 0) ? CH_NAK : CH_C);
            cancel_at = $urandom_range(4 + n_short, 8 + n_short);
            send_block(cancel_at);
        end else begin
            send_item(MODE_REPLY, rnd8(), CH_ACK);
            send_item(MODE_TICK, rnd8(), rnd8());      // nothing left: EOT
        end

        // session over: everything below is ignored
        for (int i = 0; i < 12; i++)
            send_item(2'($urandom_range(0, 3)), rnd8(),
                      (i % 3 == 0) ? CH_CAN : ((i % 3 == 1) ? CH_C : rnd8()));

        drain();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d line results from %0d input transactions, %0d blocks sent.",
                 sb.checked, items_sent, sb.blocks_sent);
        $display("Session closed by %s; short block padded with %s, block number wrapped.",
                 end_by_cancel ? "receiver cancel during a resend" : "EOT",
                 end_by_cancel ? "0, then 255 on the resend" : "0");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* xmodem_block_sender.f */
design/xbs_pkg.sv
design/xmodem_block_sender.sv
sim/xbs_tb_pkg.sv
sim/tb_top.sv
